// ===== hw/rtl/gww_pkg.sv =====
// Shared types, constants and helpers of the greedy word wrapper.
package gww_pkg;

    localparam int MAX_WIDTH_DEF   = 255;
    localparam int BPR_DEF         = 8;
    localparam int MAX_RESULTS     = 32;
    localparam int LINE_NUM_W      = 24;
    localparam int COUNT_W         = 4;
    localparam int OUT_W           = 64;

    localparam logic [7:0]            RESET_WIDTH = 8'd80;
    localparam logic [7:0]            CHAR_NL     = 8'd10;
    localparam logic [7:0]            CHAR_TAB    = 8'd9;
    localparam logic [7:0]            CHAR_VT     = 8'd11;
    localparam logic [7:0]            CHAR_FF     = 8'd12;
    localparam logic [7:0]            CHAR_CR     = 8'd13;
    localparam logic [7:0]            CHAR_SP     = 8'd32;
    localparam logic [LINE_NUM_W-1:0] LINE_MAX    = 24'hFFFFFF;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PT_FLUSH,
        S_PT_PUT,
        S_EL_START,
        S_EL_RD,
        S_EL_USE,
        S_EL_END,
        S_BRK_CHK,
        S_LO_RD,
        S_LO_USE,
        S_LO_DONE,
        S_WARN,
        S_HI_RD,
        S_HI_USE,
        S_ALL_RD,
        S_ALL_USE,
        S_CUT_RD,
        S_CUT_USE,
        S_CUT_NL,
        S_SK_RD,
        S_SK_USE,
        S_TAIL,
        S_LAST
    } ctl_state_t;

    typedef struct packed {
        logic                  put;
        logic                  flush;
        logic                  nl;
        logic                  tail;
        logic                  warn;
        logic                  fin;
        logic [7:0]            data;
        logic [LINE_NUM_W-1:0] line;
    } pk_cmd_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF) ||
               (b == CHAR_CR) || (b == CHAR_SP);
    endfunction

endpackage

// ===== hw/rtl/greedy_word_wrap.sv =====
// Top level of the greedy word wrapper: config register, line store, sequencer and packer.
//
//  channel | ports              | direction | payload
//  --------+--------------------+-----------+--------------------------------------------
//  cfg     | cfg_valid/ready    | in        | cfg_data (line width)
//  s_      | s_valid/s_ready    | in        | s_in_byte, s_end_of_text
//  m_      | m_valid/m_ready    | out       | m_out_bytes, m_byte_count, m_newline_after,
//          |                    |           | m_too_long, m_line_number, m_last
//
//  A buffered byte passes the break check, tail and last states; each store entry visited
//  in a scan takes a read of the line store and a use of its registered data.
//  A break searches entries 0..W for whitespace, then emits the bytes before the cut.
//  Synchronous active-low reset; no clearing pass, entries are read only below the fill.
//  A full output register with m_ready low stalls the sequencer; s_ready is low meanwhile.
module greedy_word_wrap #(
    parameter int MAX_WIDTH        = gww_pkg::MAX_WIDTH_DEF,
    parameter int BYTES_PER_RESULT = gww_pkg::BPR_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [7:0]                          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_in_byte,
    input  logic                                s_end_of_text,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gww_pkg::OUT_W-1:0]           m_out_bytes,
    output logic [gww_pkg::COUNT_W-1:0]         m_byte_count,
    output logic                                m_newline_after,
    output logic                                m_too_long,
    output logic [gww_pkg::LINE_NUM_W-1:0]      m_line_number,
    output logic                                m_last
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]       wrap_width_reg;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;
    gww_pkg::pk_cmd_t pk_cmd;
    logic             pk_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_width_reg <= gww_pkg::RESET_WIDTH;
        end else if (cfg_valid) begin
            wrap_width_reg <= cfg_data;
        end
    end

    gww_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    gww_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .wrap_width    (wrap_width_reg),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .cmd           (pk_cmd),
        .pk_ok         (pk_ok)
    );

    gww_pack #(
        .BPR (BYTES_PER_RESULT)
    ) u_pack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (pk_cmd),
        .ok              (pk_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_bytes     (m_out_bytes),
        .m_byte_count    (m_byte_count),
        .m_newline_after (m_newline_after),
        .m_too_long      (m_too_long),
        .m_line_number   (m_line_number),
        .m_last          (m_last)
    );

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready held high after a request");

    a_line_only_on_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_too_long |-> m_line_number == '0)
        else $error("line number without warning");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_count <= gww_pkg::COUNT_W'(BYTES_PER_RESULT))
        else $error("byte count above result size");

    a_plain_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_newline_after && !m_too_long |-> m_byte_count != '0)
        else $error("empty result without line end or warning");

endmodule

// ===== hw/rtl/gww_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/gww_pack.sv =====
// Result packer: collects bytes, holds one pending result, drives the output register.
module gww_pack #(
    parameter int BPR = gww_pkg::BPR_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gww_pkg::pk_cmd_t                  cmd,
    output logic                              ok,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gww_pkg::OUT_W-1:0]         m_out_bytes,
    output logic [gww_pkg::COUNT_W-1:0]       m_byte_count,
    output logic                              m_newline_after,
    output logic                              m_too_long,
    output logic [gww_pkg::LINE_NUM_W-1:0]    m_line_number,
    output logic                              m_last
);

    localparam int CW  = gww_pkg::COUNT_W;
    localparam int LW  = gww_pkg::LINE_NUM_W;
    localparam int OW  = gww_pkg::OUT_W;
    localparam int RCW = $clog2(gww_pkg::MAX_RESULTS + 1);

    logic [OW-1:0]  cur_bytes_reg, cur_bytes_next;
    logic [CW-1:0]  cur_cnt_reg, cur_cnt_next;
    logic           cur_warn_reg, cur_warn_next;
    logic [LW-1:0]  cur_line_reg, cur_line_next;
    logic [RCW-1:0] res_cnt_reg, res_cnt_next;

    logic           pend_valid_reg, pend_valid_next;
    logic [OW-1:0]  pend_bytes_reg, pend_bytes_next;
    logic [CW-1:0]  pend_cnt_reg, pend_cnt_next;
    logic           pend_nl_reg, pend_nl_next;
    logic           pend_warn_reg, pend_warn_next;
    logic [LW-1:0]  pend_line_reg, pend_line_next;

    logic           out_valid_reg, out_valid_next;
    logic [OW-1:0]  out_bytes_reg, out_bytes_next;
    logic [CW-1:0]  out_cnt_reg, out_cnt_next;
    logic           out_nl_reg, out_nl_next;
    logic           out_warn_reg, out_warn_next;
    logic [LW-1:0]  out_line_reg, out_line_next;
    logic           out_last_reg, out_last_next;

    logic          full;
    logic          empty;
    logic          out_free;
    logic          room;
    logic          emit_ok;
    logic          emit;
    logic          fin_ok;
    logic [OW-1:0] base_bytes;
    logic [CW-1:0] base_cnt;

    always_comb begin
        full     = (cur_cnt_reg == CW'(BPR));
        empty    = (cur_cnt_reg == '0) && !cur_warn_reg;
        out_free = !out_valid_reg || m_ready;
        room     = (res_cnt_reg < RCW'(gww_pkg::MAX_RESULTS));
        emit_ok  = !room || !pend_valid_reg || out_free;
        fin_ok   = !pend_valid_reg || out_free;
        emit     = emit_ok && ((cmd.put && full) || (cmd.flush && !(cmd.tail && empty)));

        if (cmd.put) begin
            ok = !full || emit_ok;
        end else if (cmd.flush) begin
            ok = (cmd.tail && empty) || emit_ok;
        end else if (cmd.fin) begin
            ok = fin_ok;
        end else begin
            ok = 1'b1;
        end
    end

    always_comb begin
        cur_bytes_next  = cur_bytes_reg;
        cur_cnt_next    = cur_cnt_reg;
        cur_warn_next   = cur_warn_reg;
        cur_line_next   = cur_line_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_nl_next    = pend_nl_reg;
        pend_warn_next  = pend_warn_reg;
        pend_line_next  = pend_line_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_bytes_next  = out_bytes_reg;
        out_cnt_next    = out_cnt_reg;
        out_nl_next     = out_nl_reg;
        out_warn_next   = out_warn_reg;
        out_line_next   = out_line_reg;
        out_last_next   = out_last_reg;

        if (emit) begin
            if (room) begin
                if (pend_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_bytes_next = pend_bytes_reg;
                    out_cnt_next   = pend_cnt_reg;
                    out_nl_next    = pend_nl_reg;
                    out_warn_next  = pend_warn_reg;
                    out_line_next  = pend_line_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_bytes_next = cur_bytes_reg;
                pend_cnt_next   = cur_cnt_reg;
                pend_nl_next    = cmd.flush && cmd.nl;
                pend_warn_next  = cur_warn_reg;
                pend_line_next  = cur_line_reg;
                res_cnt_next    = res_cnt_reg + 1'b1;
            end
            cur_bytes_next = '0;
            cur_cnt_next   = '0;
            cur_warn_next  = 1'b0;
            cur_line_next  = '0;
        end

        base_bytes = emit ? '0 : cur_bytes_reg;
        base_cnt   = emit ? '0 : cur_cnt_reg;
        if (cmd.put && (!full || emit_ok)) begin
            cur_bytes_next = base_bytes;
            for (int k = 0; k < BPR; k++) begin
                if (base_cnt == CW'(k)) begin
                    cur_bytes_next[8*k +: 8] = cmd.data;
                end
            end
            cur_cnt_next = base_cnt + 1'b1;
        end

        if (cmd.warn) begin
            cur_warn_next = 1'b1;
            cur_line_next = cmd.line;
        end

        if (cmd.fin && fin_ok) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_bytes_next = pend_bytes_reg;
                out_cnt_next   = pend_cnt_reg;
                out_nl_next    = pend_nl_reg;
                out_warn_next  = pend_warn_reg;
                out_line_next  = pend_line_reg;
                out_last_next  = 1'b1;
            end
            pend_valid_next = 1'b0;
            res_cnt_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_bytes_reg  <= '0;
            cur_cnt_reg    <= '0;
            cur_warn_reg   <= 1'b0;
            cur_line_reg   <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cur_bytes_reg  <= cur_bytes_next;
            cur_cnt_reg    <= cur_cnt_next;
            cur_warn_reg   <= cur_warn_next;
            cur_line_reg   <= cur_line_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_bytes_reg <= pend_bytes_next;
        pend_cnt_reg   <= pend_cnt_next;
        pend_nl_reg    <= pend_nl_next;
        pend_warn_reg  <= pend_warn_next;
        pend_line_reg  <= pend_line_next;
        out_bytes_reg  <= out_bytes_next;
        out_cnt_reg    <= out_cnt_next;
        out_nl_reg     <= out_nl_next;
        out_warn_reg   <= out_warn_next;
        out_line_reg   <= out_line_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_out_bytes     = out_bytes_reg;
    assign m_byte_count    = out_cnt_reg;
    assign m_newline_after = out_nl_reg;
    assign m_too_long      = out_warn_reg;
    assign m_line_number   = out_line_reg;
    assign m_last          = out_last_reg;

endmodule

// ===== hw/rtl/gww_ctrl.sv =====
// Line sequencer: buffers bytes in the ring store, scans it for breaks and drives the packer.
module gww_ctrl #(
    parameter int MAX_WIDTH = gww_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_in_byte,
    input  logic                                 s_end_of_text,
    input  logic [7:0]                           wrap_width,
    output logic                                 ram_we,
    output logic [$clog2(MAX_WIDTH+1)-1:0]       ram_waddr,
    output logic [7:0]                           ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(MAX_WIDTH+1)-1:0]       ram_raddr,
    input  logic [7:0]                           ram_rdata,
    output gww_pkg::pk_cmd_t                     cmd,
    input  logic                                 pk_ok
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_WIDTH + 2);
    localparam int SW    = FW + 1;
    localparam int CPW   = (FW > 8) ? FW : 8;
    localparam int LW    = gww_pkg::LINE_NUM_W;

    gww_pkg::ctl_state_t state_reg, state_next;

    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] cut_reg, cut_next;
    logic          found_reg, found_next;
    logic          seen_reg, seen_next;
    logic [7:0]    byte_reg, byte_next;
    logic          pass_reg, pass_next;
    logic          skip_reg, skip_next;
    logic          started_reg, started_next;
    logic [LW-1:0] lcount_reg, lcount_next;

    logic [CPW-1:0] lw_ext;
    logic [CPW-1:0] ew_wide;
    logic [FW-1:0]  ew;
    logic [FW-1:0]  idx_inc;
    logic           accept;
    logic           in_ws;
    logic           rd_ws;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [FW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return AW'(s);
    endfunction

    always_comb begin
        lw_ext = CPW'(wrap_width);
        if (lw_ext == '0) begin
            ew_wide = CPW'(1);
        end else if (lw_ext > CPW'(MAX_WIDTH)) begin
            ew_wide = CPW'(MAX_WIDTH);
        end else begin
            ew_wide = lw_ext;
        end
        ew      = FW'(ew_wide);
        idx_inc = idx_reg + 1'b1;
        accept  = s_valid && (state_reg == gww_pkg::S_IDLE);
        in_ws   = gww_pkg::is_ws(s_in_byte);
        rd_ws   = gww_pkg::is_ws(ram_rdata);
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        idx_next     = idx_reg;
        cut_next     = cut_reg;
        found_next   = found_reg;
        seen_next    = seen_reg;
        byte_next    = byte_reg;
        pass_next    = pass_reg;
        skip_next    = skip_reg;
        started_next = started_reg;
        lcount_next  = lcount_reg;

        case (state_reg)
            gww_pkg::S_IDLE: begin
                if (accept) begin
                    byte_next = s_in_byte;
                    if (s_end_of_text) begin
                        lcount_next = '0;
                        state_next  = started_reg ? gww_pkg::S_EL_START : gww_pkg::S_TAIL;
                    end else begin
                        if (!started_reg) begin
                            started_next = 1'b1;
                            if (lcount_reg != gww_pkg::LINE_MAX) begin
                                lcount_next = lcount_reg + 1'b1;
                            end
                        end
                        if (s_in_byte == gww_pkg::CHAR_NL) begin
                            state_next = gww_pkg::S_EL_START;
                        end else if (pass_reg) begin
                            state_next = in_ws ? gww_pkg::S_PT_FLUSH : gww_pkg::S_PT_PUT;
                        end else if (!(skip_reg && in_ws)) begin
                            skip_next  = 1'b0;
                            fill_next  = fill_reg + 1'b1;
                            state_next = gww_pkg::S_BRK_CHK;
                        end else begin
                            state_next = gww_pkg::S_TAIL;
                        end
                    end
                end
            end
            gww_pkg::S_PT_FLUSH: begin
                if (pk_ok) begin
                    pass_next  = 1'b0;
                    skip_next  = 1'b1;
                    state_next = gww_pkg::S_TAIL;
                end
            end
            gww_pkg::S_PT_PUT: begin
                if (pk_ok) begin
                    state_next = gww_pkg::S_TAIL;
                end
            end
            gww_pkg::S_EL_START: begin
                seen_next = 1'b0;
                idx_next  = '0;
                if (pass_reg) begin
                    if (pk_ok) begin
                        state_next = gww_pkg::S_EL_END;
                    end
                end else if (fill_reg == '0) begin
                    state_next = gww_pkg::S_EL_END;
                end else begin
                    state_next = gww_pkg::S_EL_RD;
                end
            end
            gww_pkg::S_EL_RD: begin
                state_next = gww_pkg::S_EL_USE;
            end
            gww_pkg::S_EL_USE: begin
                if (pk_ok) begin
                    if (seen_reg || !rd_ws) begin
                        seen_next = 1'b1;
                    end
                    idx_next   = idx_inc;
                    state_next = (idx_inc == fill_reg) ? gww_pkg::S_EL_END : gww_pkg::S_EL_RD;
                end
            end
            gww_pkg::S_EL_END: begin
                if (pk_ok) begin
                    fill_next    = '0;
                    pass_next    = 1'b0;
                    skip_next    = 1'b0;
                    started_next = 1'b0;
                    state_next   = gww_pkg::S_TAIL;
                end
            end
            gww_pkg::S_BRK_CHK: begin
                idx_next   = '0;
                found_next = 1'b0;
                state_next = (fill_reg > ew) ? gww_pkg::S_LO_RD : gww_pkg::S_TAIL;
            end
            gww_pkg::S_LO_RD: begin
                state_next = gww_pkg::S_LO_USE;
            end
            gww_pkg::S_LO_USE: begin
                if (rd_ws) begin
                    found_next = 1'b1;
                    cut_next   = idx_reg;
                end
                idx_next   = idx_inc;
                state_next = (idx_reg == ew) ? gww_pkg::S_LO_DONE : gww_pkg::S_LO_RD;
            end
            gww_pkg::S_LO_DONE: begin
                idx_next = '0;
                if (!found_reg) begin
                    state_next = gww_pkg::S_WARN;
                end else if (cut_reg == '0) begin
                    state_next = gww_pkg::S_CUT_NL;
                end else begin
                    state_next = gww_pkg::S_CUT_RD;
                end
            end
            gww_pkg::S_WARN: begin
                if (ew + 1'b1 < fill_reg) begin
                    idx_next   = ew + 1'b1;
                    state_next = gww_pkg::S_HI_RD;
                end else begin
                    idx_next   = '0;
                    state_next = gww_pkg::S_ALL_RD;
                end
            end
            gww_pkg::S_HI_RD: begin
                state_next = gww_pkg::S_HI_USE;
            end
            gww_pkg::S_HI_USE: begin
                if (rd_ws) begin
                    cut_next   = idx_reg;
                    idx_next   = '0;
                    state_next = gww_pkg::S_CUT_RD;
                end else if (idx_inc == fill_reg) begin
                    idx_next   = '0;
                    state_next = gww_pkg::S_ALL_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = gww_pkg::S_HI_RD;
                end
            end
            gww_pkg::S_ALL_RD: begin
                state_next = gww_pkg::S_ALL_USE;
            end
            gww_pkg::S_ALL_USE: begin
                if (pk_ok) begin
                    idx_next = idx_inc;
                    if (idx_inc == fill_reg) begin
                        fill_next  = '0;
                        pass_next  = 1'b1;
                        state_next = gww_pkg::S_TAIL;
                    end else begin
                        state_next = gww_pkg::S_ALL_RD;
                    end
                end
            end
            gww_pkg::S_CUT_RD: begin
                state_next = gww_pkg::S_CUT_USE;
            end
            gww_pkg::S_CUT_USE: begin
                if (pk_ok) begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cut_reg) ? gww_pkg::S_CUT_NL : gww_pkg::S_CUT_RD;
                end
            end
            gww_pkg::S_CUT_NL: begin
                if (pk_ok) begin
                    idx_next = cut_reg + 1'b1;
                    if (cut_reg + 1'b1 >= fill_reg) begin
                        fill_next  = '0;
                        skip_next  = 1'b1;
                        state_next = gww_pkg::S_BRK_CHK;
                    end else begin
                        state_next = gww_pkg::S_SK_RD;
                    end
                end
            end
            gww_pkg::S_SK_RD: begin
                state_next = gww_pkg::S_SK_USE;
            end
            gww_pkg::S_SK_USE: begin
                if (rd_ws) begin
                    idx_next = idx_inc;
                    if (idx_inc >= fill_reg) begin
                        fill_next  = '0;
                        skip_next  = 1'b1;
                        state_next = gww_pkg::S_BRK_CHK;
                    end else begin
                        state_next = gww_pkg::S_SK_RD;
                    end
                end else begin
                    head_next  = phys(head_reg, idx_reg);
                    fill_next  = fill_reg - idx_reg;
                    state_next = gww_pkg::S_BRK_CHK;
                end
            end
            gww_pkg::S_TAIL: begin
                if (pk_ok) begin
                    state_next = gww_pkg::S_LAST;
                end
            end
            gww_pkg::S_LAST: begin
                if (pk_ok) begin
                    state_next = gww_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gww_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == gww_pkg::S_IDLE);
        ram_we    = accept && !s_end_of_text && (s_in_byte != gww_pkg::CHAR_NL) &&
                    !pass_reg && !(skip_reg && in_ws);
        ram_waddr = phys(head_reg, fill_reg);
        ram_wdata = s_in_byte;
        ram_re    = 1'b0;
        ram_raddr = phys(head_reg, idx_reg);
        cmd       = '0;
        cmd.data  = ram_rdata;
        cmd.line  = lcount_reg;

        case (state_reg)
            gww_pkg::S_EL_RD, gww_pkg::S_LO_RD, gww_pkg::S_HI_RD,
            gww_pkg::S_ALL_RD, gww_pkg::S_CUT_RD, gww_pkg::S_SK_RD: begin
                ram_re = 1'b1;
            end
            gww_pkg::S_PT_FLUSH, gww_pkg::S_CUT_NL: begin
                cmd.flush = 1'b1;
                cmd.nl    = 1'b1;
            end
            gww_pkg::S_PT_PUT: begin
                cmd.put  = 1'b1;
                cmd.data = byte_reg;
            end
            gww_pkg::S_EL_START: begin
                cmd.flush = pass_reg;
                cmd.nl    = 1'b1;
            end
            gww_pkg::S_EL_USE: begin
                cmd.put = seen_reg || !rd_ws;
            end
            gww_pkg::S_EL_END: begin
                cmd.flush = seen_reg;
                cmd.nl    = 1'b1;
            end
            gww_pkg::S_WARN: begin
                cmd.warn = 1'b1;
            end
            gww_pkg::S_ALL_USE, gww_pkg::S_CUT_USE: begin
                cmd.put = 1'b1;
            end
            gww_pkg::S_TAIL: begin
                cmd.flush = 1'b1;
                cmd.tail  = 1'b1;
            end
            gww_pkg::S_LAST: begin
                cmd.fin = 1'b1;
            end
            default: begin
                cmd.put = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gww_pkg::S_IDLE;
            fill_reg    <= '0;
            head_reg    <= '0;
            pass_reg    <= 1'b0;
            skip_reg    <= 1'b0;
            started_reg <= 1'b0;
            lcount_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            pass_reg    <= pass_next;
            skip_reg    <= skip_next;
            started_reg <= started_next;
            lcount_reg  <= lcount_next;
        end
        idx_reg   <= idx_next;
        cut_reg   <= cut_next;
        found_reg <= found_next;
        seen_reg  <= seen_next;
        byte_reg  <= byte_next;
    end

endmodule

// ===== tb/sv/gww_checker.sv =====
// Checker for the greedy word wrapper: watches the channels, predicts the output and compares.
`timescale 1ns / 100ps

module gww_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [7:0]                       cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [7:0]                       s_in_byte,
    input  logic                             s_end_of_text,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [gww_pkg::OUT_W-1:0]        m_out_bytes,
    input  logic [gww_pkg::COUNT_W-1:0]      m_byte_count,
    input  logic                             m_newline_after,
    input  logic                             m_too_long,
    input  logic [gww_pkg::LINE_NUM_W-1:0]   m_line_number,
    input  logic                             m_last,
    output int                               fail_count,
    output int                               outstanding
);

    typedef struct packed {
        logic [gww_pkg::OUT_W-1:0]      data;
        logic [gww_pkg::COUNT_W-1:0]    count;
        logic                           nl;
        logic                           warn;
        logic [gww_pkg::LINE_NUM_W-1:0] line;
        logic                           last;
    } wrap_out_t;

    wrap_out_t   expected_out_q[$];
    wrap_out_t   step_q[$];

    logic [7:0]  width_reg;
    logic [7:0]  line_buf [0:255];
    int unsigned fill;
    bit          pass_thru;
    bit          skip_ws;
    bit          started;
    int unsigned line_no;
    logic [gww_pkg::OUT_W-1:0] cur_data;
    int unsigned cur_cnt;
    bit          cur_warn;
    int unsigned cur_line;

    assign outstanding = expected_out_q.size();

    function automatic bit is_blank(input logic [7:0] b);
        return b == gww_pkg::CHAR_TAB || b == gww_pkg::CHAR_VT || b == gww_pkg::CHAR_FF ||
               b == gww_pkg::CHAR_CR || b == gww_pkg::CHAR_SP;
    endfunction

    task emit(input bit nl);
        wrap_out_t r;
        if (step_q.size() < gww_pkg::MAX_RESULTS) begin
            r.data  = cur_data;
            r.count = cur_cnt[gww_pkg::COUNT_W-1:0];
            r.nl    = nl;
            r.warn  = cur_warn;
            r.line  = cur_warn ? cur_line[gww_pkg::LINE_NUM_W-1:0] : '0;
            r.last  = 1'b0;
            step_q.push_back(r);
        end
        cur_data = '0;
        cur_cnt  = 0;
        cur_warn = 0;
        cur_line = 0;
    endtask

    task put_byte(input logic [7:0] b);
        if (cur_cnt >= gww_pkg::BPR_DEF)
            emit(1'b0);
        cur_data = cur_data | (gww_pkg::OUT_W'(b) << (8 * cur_cnt));
        cur_cnt++;
    endtask

    task cut_line(input int unsigned cut);
        int unsigned i;
        int unsigned j;
        for (i = 0; i < cut; i++)
            put_byte(line_buf[i]);
        emit(1'b1);
        j = cut + 1;
        while (j < fill && is_blank(line_buf[j]))
            j++;
        if (j >= fill) begin
            fill    = 0;
            skip_ws = 1;
        end else begin
            for (i = 0; i < fill - j; i++)
                line_buf[i] = line_buf[i + j];
            fill = fill - j;
        end
    endtask

    task break_lines();
        int unsigned w;
        int unsigned i;
        int unsigned cut;
        bit found;
        w = (width_reg == 0) ? 1 : width_reg;
        while (fill > w) begin
            found = 0;
            cut   = 0;
            for (i = 0; i <= w; i++) begin
                if (is_blank(line_buf[i])) begin
                    found = 1;
                    cut   = i;
                end
            end
            if (!found) begin
                cur_warn = 1;
                cur_line = line_no;
                for (i = w + 1; i < fill && !found; i++) begin
                    if (is_blank(line_buf[i])) begin
                        found = 1;
                        cut   = i;
                    end
                end
                if (!found) begin
                    for (i = 0; i < fill; i++)
                        put_byte(line_buf[i]);
                    fill      = 0;
                    pass_thru = 1;
                    return;
                end
            end
            cut_line(cut);
        end
    endtask

    task close_line();
        int unsigned s;
        int unsigned i;
        if (pass_thru) begin
            emit(1'b1);
        end else begin
            s = 0;
            while (s < fill && is_blank(line_buf[s]))
                s++;
            if (s < fill) begin
                for (i = s; i < fill; i++)
                    put_byte(line_buf[i]);
                emit(1'b1);
            end
        end
        fill      = 0;
        pass_thru = 0;
        skip_ws   = 0;
        started   = 0;
    endtask

    task predict_wrap(input logic [7:0] b, input logic eot);
        step_q.delete();
        cur_data = '0;
        cur_cnt  = 0;
        cur_warn = 0;
        cur_line = 0;
        if (eot) begin
            if (started)
                close_line();
            line_no = 0;
        end else begin
            if (!started) begin
                started = 1;
                if (line_no < gww_pkg::LINE_MAX)
                    line_no++;
            end
            if (b == gww_pkg::CHAR_NL) begin
                close_line();
            end else if (pass_thru) begin
                if (is_blank(b)) begin
                    emit(1'b1);
                    pass_thru = 0;
                    skip_ws   = 1;
                end else begin
                    put_byte(b);
                end
            end else if (!(skip_ws && is_blank(b))) begin
                skip_ws        = 0;
                line_buf[fill] = b;
                fill++;
                break_lines();
            end
        end
        if (cur_cnt > 0 || cur_warn)
            emit(1'b0);
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[k])
            expected_out_q.push_back(step_q[k]);
    endtask

    always @(posedge aclk) begin
        wrap_out_t exp_r;
        if (!aresetn) begin
            width_reg = gww_pkg::RESET_WIDTH;
            fill      = 0;
            pass_thru = 0;
            skip_ws   = 0;
            started   = 0;
            line_no   = 0;
            expected_out_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                width_reg = cfg_data;
            if (s_valid && s_ready)
                predict_wrap(s_in_byte, s_end_of_text);
            if (m_valid && m_ready) begin
                if (expected_out_q.size() == 0) begin
                    $display("%0t: unexpected result data=%h count=%0d", $time, m_out_bytes,
                             m_byte_count);
                    fail_count++;
                end else begin
                    exp_r = expected_out_q.pop_front();
                    if (m_out_bytes !== exp_r.data || m_byte_count !== exp_r.count ||
                        m_newline_after !== exp_r.nl || m_too_long !== exp_r.warn ||
                        m_line_number !== exp_r.line || m_last !== exp_r.last) begin
                        $display({"%0t: mismatch expected data=%h cnt=%0d nl=%b warn=%b",
                                  " line=%0d last=%b"},
                                 $time, exp_r.data, exp_r.count, exp_r.nl, exp_r.warn,
                                 exp_r.line, exp_r.last);
                        $display({"%0t:          actual   data=%h cnt=%0d nl=%b warn=%b",
                                  " line=%0d last=%b"},
                                 $time, m_out_bytes, m_byte_count, m_newline_after, m_too_long,
                                 m_line_number, m_last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_greedy_word_wrap.sv =====
// Testbench top for the greedy word wrapper: clock, reset, text stimulus and verdict.
`timescale 1ns / 100ps

module tb_greedy_word_wrap;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [7:0]                     cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [7:0]                     s_in_byte;
    logic                           s_end_of_text;
    logic                           m_valid;
    logic                           m_ready;
    logic [gww_pkg::OUT_W-1:0]      m_out_bytes;
    logic [gww_pkg::COUNT_W-1:0]    m_byte_count;
    logic                           m_newline_after;
    logic                           m_too_long;
    logic [gww_pkg::LINE_NUM_W-1:0] m_line_number;
    logic                           m_last;
    int                             fail_count;
    int                             outstanding;
    int                             send_idle_pct;
    int                             stall_pct;
    bit                             start_hold;
    bit                             hold_off;

    greedy_word_wrap u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_bytes     (m_out_bytes),
        .m_byte_count    (m_byte_count),
        .m_newline_after (m_newline_after),
        .m_too_long      (m_too_long),
        .m_line_number   (m_line_number),
        .m_last          (m_last)
    );

    gww_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_bytes     (m_out_bytes),
        .m_byte_count    (m_byte_count),
        .m_newline_after (m_newline_after),
        .m_too_long      (m_too_long),
        .m_line_number   (m_line_number),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("tb_greedy_word_wrap: errors");
        $finish;
    end

    initial begin
        hold_off = 1'b0;
        wait (start_hold);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (600) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0: return gww_pkg::CHAR_TAB;
            1: return gww_pkg::CHAR_VT;
            2: return gww_pkg::CHAR_FF;
            3: return gww_pkg::CHAR_CR;
            default: return gww_pkg::CHAR_SP;
        endcase
    endfunction

    task send_char(input logic [7:0] b, input logic eot);
        bit ok;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_end_of_text <= eot;
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
    endtask

    task send_text(input string txt);
        foreach (txt[i])
            send_char(txt[i], 1'b0);
    endtask

    task set_width(input logic [7:0] w);
        bit ok;
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (1200) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do begin
            @(negedge aclk);
            ok = cfg_ready;
            @(posedge aclk);
        end while (!ok);
        cfg_valid <= 1'b0;
    endtask

    task send_random_text(input int count);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_char(8'($urandom_range(255)), 1'b0);
                sent++;
            end else if (r < 10) begin
                send_char(8'($urandom_range(255)), 1'b1);
                sent++;
            end else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
                repeat (len) begin
                    send_char(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
                    sent++;
                end
                r = $urandom_range(99);
                if (r < 15) begin
                    send_char(gww_pkg::CHAR_NL, 1'b0);
                    sent++;
                end else if (r < 25) begin
                    repeat ($urandom_range(2, 4)) begin
                        send_char(pick_blank(), 1'b0);
                        sent++;
                    end
                end else begin
                    send_char(pick_blank(), 1'b0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_in_byte     = '0;
        s_end_of_text = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        start_hold    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_char(8'h00, 1'b1);
        send_text("  lead\tx\vy\fz\rw end\n");
        send_char(gww_pkg::CHAR_NL, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h41, 1'b1);
        set_width(8'd0);
        send_text("a bc defgh ij\n");
        set_width(8'd4);
        send_text("abcdefg hi");
        send_char(8'h00, 1'b1);
        set_width(8'd255);
        send_text("a b c d e f g h i j k l m n o p q r s t u v w x y z ");
        send_text("a b c d e f g h i j k l m n o p q r s t u v w x y z ");
        set_width(8'd1);
        send_text("x\n");

        set_width(8'd20);
        start_hold = 1;
        send_random_text(60);

        set_width(8'd255);
        send_idle_pct = 65;
        stall_pct     = 0;
        send_random_text(45);

        set_width(8'd6);
        send_idle_pct = 0;
        stall_pct     = 65;
        send_random_text(45);

        set_width(8'($urandom_range(1, 30)));
        send_idle_pct = 29;
        stall_pct     = 29;
        send_random_text(45);

        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (1200) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_greedy_word_wrap: clean");
        else
            $display("tb_greedy_word_wrap: errors");
        $finish;
    end

endmodule
